// ===== rtl/rab_pkg.sv =====
// Shared types and constants for the ray / box face hit test.
// Used by ray_aabb_face_hit_test_core and rab_face_unit; depends on nothing.

package rab_pkg;

  // Width of every ray field and box register, Q16.16.
  localparam int DW = 32;
  // Widths of the direction threshold and widening rate registers.
  localparam int THR_W = 31;
  localparam int EPS_W = 17;
  // Position of the binary point, also the split point of wide products.
  localparam int FRAC_W = 16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_BOX_LOW_X  = 3'd0,
    CFG_BOX_LOW_Y  = 3'd1,
    CFG_BOX_LOW_Z  = 3'd2,
    CFG_BOX_HIGH_X = 3'd3,
    CFG_BOX_HIGH_Y = 3'd4,
    CFG_BOX_HIGH_Z = 3'd5,
    CFG_DIR_THR    = 3'd6,
    CFG_EPS_RATE   = 3'd7
  } cfg_idx_t;

  // Stage load enables for the face test pipeline.
  typedef struct packed {
    logic s5;
    logic s6;
    logic s7;
    logic s8;
  } rab_adv_t;

endpackage

// ===== rtl/rab_face_unit.sv =====
// Face test pipeline for one normal axis: plane select, products, sums, bound compares.
// Depends on rab_pkg; instantiated three times by ray_aabb_face_hit_test_core.

module rab_face_unit #(
  parameter int CW = 32
) (
  input  logic                            clk,
  input  rab_pkg::rab_adv_t               adv,
  input  logic                            neg_i,
  input  logic                            pos_i,
  input  logic signed [rab_pkg::DW-1:0]   pa_i,
  input  logic signed [rab_pkg::DW-1:0]   pb_i,
  input  logic signed [rab_pkg::DW-1:0]   pc_i,
  input  logic signed [rab_pkg::DW-1:0]   da_i,
  input  logic signed [rab_pkg::DW-1:0]   db_i,
  input  logic signed [rab_pkg::DW-1:0]   dc_i,
  input  logic signed [CW-1:0]            la_i,
  input  logic signed [CW-1:0]            ha_i,
  input  logic signed [CW-1:0]            lb_i,
  input  logic signed [CW-1:0]            hb_i,
  input  logic signed [CW-1:0]            lc_i,
  input  logic signed [CW-1:0]            hc_i,
  output logic                            hit_o
);
  import rab_pkg::*;

  // Operand widths: bounds are widened to at least the ray field width.
  localparam int AW  = (CW > DW) ? CW : DW;
  localparam int FW  = AW + 1;
  localparam int SPL = FRAC_W;
  localparam int PW  = AW + 34;
  localparam int LW  = SPL + 1 + DW;
  localparam int FHW = FW - SPL + DW;
  localparam int BHW = AW - SPL + DW;

  // Stage 5: plane select and offset from origin.
  logic signed [CW-1:0] plane;
  logic signed [FW-1:0] fd5_r;
  logic signed [AW-1:0] bnd5_r [4];
  logic signed [DW-1:0] pb5_r, pc5_r, da5_r, db5_r, dc5_r;
  logic                 neg5_r, test5_r;

  assign plane = neg_i ? ha_i : la_i;

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      fd5_r     <= FW'(plane) - FW'(pa_i);
      bnd5_r[0] <= AW'(lb_i);
      bnd5_r[1] <= AW'(hb_i);
      bnd5_r[2] <= AW'(lc_i);
      bnd5_r[3] <= AW'(hc_i);
      pb5_r     <= pb_i;
      pc5_r     <= pc_i;
      da5_r     <= da_i;
      db5_r     <= db_i;
      dc5_r     <= dc_i;
      neg5_r    <= neg_i;
      test5_r   <= neg_i | pos_i;
    end
  end

  // Stage 6: partial products; wide operands are split at the binary point.
  logic signed [2*DW-1:0] pbda6_r, pcda6_r;
  logic signed [LW-1:0]   fdb_lo6_r, fdc_lo6_r;
  logic signed [FHW-1:0]  fdb_hi6_r, fdc_hi6_r;
  logic signed [LW-1:0]   bnd_lo6_r [4];
  logic signed [BHW-1:0]  bnd_hi6_r [4];
  logic                   neg6_r, test6_r;

  always_ff @(posedge clk) begin
    if (adv.s6) begin
      pbda6_r   <= pb5_r * da5_r;
      pcda6_r   <= pc5_r * da5_r;
      fdb_lo6_r <= $signed({1'b0, fd5_r[SPL-1:0]}) * db5_r;
      fdb_hi6_r <= $signed(fd5_r[FW-1:SPL]) * db5_r;
      fdc_lo6_r <= $signed({1'b0, fd5_r[SPL-1:0]}) * dc5_r;
      fdc_hi6_r <= $signed(fd5_r[FW-1:SPL]) * dc5_r;
      for (int j = 0; j < 4; j++) begin
        bnd_lo6_r[j] <= $signed({1'b0, bnd5_r[j][SPL-1:0]}) * da5_r;
        bnd_hi6_r[j] <= $signed(bnd5_r[j][AW-1:SPL]) * da5_r;
      end
      neg6_r  <= neg5_r;
      test6_r <= test5_r;
    end
  end

  // Stage 7: recombine partial products into exact crossing and bound terms.
  logic signed [PW-1:0] ub7_r, uc7_r;
  logic signed [PW-1:0] bnd7_r [4];
  logic                 neg7_r, test7_r;

  always_ff @(posedge clk) begin
    if (adv.s7) begin
      ub7_r <= PW'(pbda6_r) + (PW'(fdb_hi6_r) <<< SPL) + PW'(fdb_lo6_r);
      uc7_r <= PW'(pcda6_r) + (PW'(fdc_hi6_r) <<< SPL) + PW'(fdc_lo6_r);
      for (int j = 0; j < 4; j++) begin
        bnd7_r[j] <= (PW'(bnd_hi6_r[j]) <<< SPL) + PW'(bnd_lo6_r[j]);
      end
      neg7_r  <= neg6_r;
      test7_r <= test6_r;
    end
  end

  // Stage 8: bound compares; the order flips for a negative direction.
  logic in_b_pos, in_c_pos, in_b_neg, in_c_neg;
  logic hit8_r;

  assign in_b_pos = (bnd7_r[0] <= ub7_r) && (ub7_r <= bnd7_r[1]);
  assign in_c_pos = (bnd7_r[2] <= uc7_r) && (uc7_r <= bnd7_r[3]);
  assign in_b_neg = (ub7_r <= bnd7_r[0]) && (bnd7_r[1] <= ub7_r);
  assign in_c_neg = (uc7_r <= bnd7_r[2]) && (bnd7_r[3] <= uc7_r);

  always_ff @(posedge clk) begin
    if (adv.s8) begin
      hit8_r <= test7_r && (neg7_r ? (in_b_neg && in_c_neg) : (in_b_pos && in_c_pos));
    end
  end

  assign hit_o = hit8_r;

endmodule

// ===== rtl/ray_aabb_face_hit_test_core.sv =====
// Top level of the ray / axis-aligned box face hit test: config registers, box widening,
// valid pipeline and output register. Depends on rab_pkg and rab_face_unit.
//
//   Channel  Direction  Handshake               Payload
//   in_      in         in_valid / in_ready     origin x/y/z, dir x/y/z (Q16.16)
//   out_     out        out_valid / out_ready   hit
//   cfg_     in         cfg_we                  cfg_index, cfg_wdata
//
// One request enters per cycle unless an output stall has filled every stage; results leave in order.
// The nine stages are: input register, center distance, widening product, saturation,
// then four face stages (plane offset, partial products, recombine, compare) and the
// output register. Every stage holds a valid bit and loads when it is empty or when the stage
// after it can move, so an output stall fills bubbles first and then holds in_ready low.
// Reset is synchronous; it clears the valid bits and loads the register reset values.

module ray_aabb_face_hit_test_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [rab_pkg::DW-1:0]  in_origin_x,
  input  logic signed [rab_pkg::DW-1:0]  in_origin_y,
  input  logic signed [rab_pkg::DW-1:0]  in_origin_z,
  input  logic signed [rab_pkg::DW-1:0]  in_dir_x,
  input  logic signed [rab_pkg::DW-1:0]  in_dir_y,
  input  logic signed [rab_pkg::DW-1:0]  in_dir_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  input  logic                           cfg_we,
  input  rab_pkg::cfg_idx_t              cfg_index,
  input  logic [rab_pkg::DW-1:0]         cfg_wdata
);
  import rab_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int NSTG   = 9;
  localparam int PROD_W = EPS_W + DW;
  localparam int EPS_OW = PROD_W - FRAC_W;
  localparam int SW     = (CW + 1 > DW + 3) ? CW + 1 : DW + 3;

  // Configuration registers.
  logic signed [DW-1:0] box_lo_r [3];
  logic signed [DW-1:0] box_hi_r [3];
  logic [THR_W-1:0]     thr_r;
  logic [EPS_W-1:0]     eps_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        box_lo_r[i] <= '0;
        box_hi_r[i] <= '0;
      end
      thr_r      <= THR_W'(1);
      eps_rate_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_LOW_X:  box_lo_r[0] <= cfg_wdata;
        CFG_BOX_LOW_Y:  box_lo_r[1] <= cfg_wdata;
        CFG_BOX_LOW_Z:  box_lo_r[2] <= cfg_wdata;
        CFG_BOX_HIGH_X: box_hi_r[0] <= cfg_wdata;
        CFG_BOX_HIGH_Y: box_hi_r[1] <= cfg_wdata;
        CFG_BOX_HIGH_Z: box_hi_r[2] <= cfg_wdata;
        CFG_DIR_THR:    thr_r       <= cfg_wdata[THR_W-1:0];
        CFG_EPS_RATE:   eps_rate_r  <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and stage enables; a stage loads when it is empty or its successor moves.
  logic [NSTG:1]   v_r;
  logic [NSTG:1]   v_nxt;
  logic [NSTG+1:1] en;

  always_comb begin
    en[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[1] = en[1] ? in_valid : v_r[1];
    for (int k = 2; k <= NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NSTG];

  // Stage 1: input register.
  logic signed [DW-1:0] p1_r [3], d1_r [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_r[0] <= in_origin_x;
      p1_r[1] <= in_origin_y;
      p1_r[2] <= in_origin_z;
      d1_r[0] <= in_dir_x;
      d1_r[1] <= in_dir_y;
      d1_r[2] <= in_dir_z;
    end
  end

  // Stage 2: distance from origin to box center per axis, and threshold tests.
  logic signed [DW:0]   ctr_sum [3];
  logic signed [DW:0]   ctr [3];
  logic signed [DW+1:0] ctr_diff [3];
  logic [DW-1:0]        mag_nxt [3];
  logic [2:0]           neg_nxt, pos_nxt;
  logic [DW-1:0]        m2_r [3];
  logic signed [DW-1:0] p2_r [3], d2_r [3];
  logic [2:0]           neg2_r, pos2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr_sum[i]  = (DW+1)'(box_lo_r[i]) + (DW+1)'(box_hi_r[i]);
      ctr[i]      = ctr_sum[i] >>> 1;
      ctr_diff[i] = (DW+2)'(p1_r[i]) - (DW+2)'(ctr[i]);
      mag_nxt[i]  = ctr_diff[i][DW+1] ? DW'(-ctr_diff[i]) : DW'(ctr_diff[i]);
      neg_nxt[i]  = (DW+1)'(d1_r[i]) < -$signed({2'b00, thr_r});
      pos_nxt[i]  = d1_r[i] > $signed({1'b0, thr_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m2_r   <= mag_nxt;
      p2_r   <= p1_r;
      d2_r   <= d1_r;
      neg2_r <= neg_nxt;
      pos2_r <= pos_nxt;
    end
  end

  // Stage 3: Chebyshev distance and widening product.
  logic [DW-1:0]        cheb_dist;
  logic [PROD_W-1:0]    prod3_r;
  logic signed [DW-1:0] p3_r [3], d3_r [3];
  logic [2:0]           neg3_r, pos3_r;

  always_comb begin
    cheb_dist = m2_r[0];
    if (m2_r[1] > cheb_dist) cheb_dist = m2_r[1];
    if (m2_r[2] > cheb_dist) cheb_dist = m2_r[2];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      prod3_r <= PROD_W'(eps_rate_r) * PROD_W'(cheb_dist);
      p3_r    <= p2_r;
      d3_r    <= d2_r;
      neg3_r  <= neg2_r;
      pos3_r  <= pos2_r;
    end
  end

  // Stage 4: widened bounds, clamped to the coordinate range.
  function automatic logic signed [CW-1:0] sat_f(input logic signed [SW-1:0] v);
    logic signed [CW-1:0] r;
    if (&v[SW-1:CW-1] || ~|v[SW-1:CW-1]) begin
      r = v[CW-1:0];
    end else if (v[SW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  logic [EPS_OW-1:0]    eps_amt;
  logic signed [SW-1:0] eps_ext;
  logic signed [CW-1:0] lo4_r [3], hi4_r [3];
  logic signed [DW-1:0] p4_r [3], d4_r [3];
  logic [2:0]           neg4_r, pos4_r;

  assign eps_amt = prod3_r[PROD_W-1:FRAC_W];
  assign eps_ext = $signed({{(SW-EPS_OW){1'b0}}, eps_amt});

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        lo4_r[i] <= sat_f(SW'(box_lo_r[i]) - eps_ext);
        hi4_r[i] <= sat_f(SW'(box_hi_r[i]) + eps_ext);
      end
      p4_r   <= p3_r;
      d4_r   <= d3_r;
      neg4_r <= neg3_r;
      pos4_r <= pos3_r;
    end
  end

  // Stages 5 to 8: one face unit per normal axis.
  rab_adv_t   adv;
  logic [2:0] face_hit;

  assign adv = '{s5: en[5], s6: en[6], s7: en[7], s8: en[8]};

  rab_face_unit #(.CW(CW)) u_face_z (
    .clk(clk), .adv(adv), .neg_i(neg4_r[2]), .pos_i(pos4_r[2]),
    .pa_i(p4_r[2]), .pb_i(p4_r[0]), .pc_i(p4_r[1]),
    .da_i(d4_r[2]), .db_i(d4_r[0]), .dc_i(d4_r[1]),
    .la_i(lo4_r[2]), .ha_i(hi4_r[2]), .lb_i(lo4_r[0]), .hb_i(hi4_r[0]),
    .lc_i(lo4_r[1]), .hc_i(hi4_r[1]), .hit_o(face_hit[2])
  );

  rab_face_unit #(.CW(CW)) u_face_x (
    .clk(clk), .adv(adv), .neg_i(neg4_r[0]), .pos_i(pos4_r[0]),
    .pa_i(p4_r[0]), .pb_i(p4_r[1]), .pc_i(p4_r[2]),
    .da_i(d4_r[0]), .db_i(d4_r[1]), .dc_i(d4_r[2]),
    .la_i(lo4_r[0]), .ha_i(hi4_r[0]), .lb_i(lo4_r[1]), .hb_i(hi4_r[1]),
    .lc_i(lo4_r[2]), .hc_i(hi4_r[2]), .hit_o(face_hit[0])
  );

  rab_face_unit #(.CW(CW)) u_face_y (
    .clk(clk), .adv(adv), .neg_i(neg4_r[1]), .pos_i(pos4_r[1]),
    .pa_i(p4_r[1]), .pb_i(p4_r[0]), .pc_i(p4_r[2]),
    .da_i(d4_r[1]), .db_i(d4_r[0]), .dc_i(d4_r[2]),
    .la_i(lo4_r[1]), .ha_i(hi4_r[1]), .lb_i(lo4_r[0]), .hb_i(hi4_r[0]),
    .lc_i(lo4_r[2]), .hc_i(hi4_r[2]), .hit_o(face_hit[1])
  );

  // Stage 9: output register.
  logic hit9_r;

  always_ff @(posedge clk) begin
    if (en[NSTG]) begin
      hit9_r <= |face_hit;
    end
  end

  assign out_hit = hit9_r;

  // Checks on the valid pipeline.
  logic in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // A request is refused only when every stage is full and the output is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_r != '1) |-> in_ready)
    else $error("request refused while the pipeline has a free stage");

  assert property (@(posedge clk) disable iff (!rst_n)
    ((v_r == '1) && !out_ready) |-> !in_ready)
    else $error("request taken while a full pipeline is stalled");

  // The number of requests in flight changes only by accepts and deliveries.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $countones($past(v_r))
                      + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("request lost or repeated in the pipeline");

endmodule
